>>> design/rlec_pkg.sv
// Shared types and codes for the refcounted LRU entry cache.
package rlec_pkg;

  localparam int OP_BITS     = 3;
  localparam int STATUS_BITS = 3;
  localparam int SLOT_BITS   = 6;
  localparam int REF_BITS    = 16;
  localparam int AGE_BITS    = 32;
  localparam int CNT_BITS    = 32;
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOOKUP = 3'd0,
    OP_GET    = 3'd1,
    OP_ADDREF = 3'd2,
    OP_DROP   = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_HIT     = 3'd0,
    ST_CREATED = 3'd1,
    ST_MISS    = 3'd2,
    ST_FULL    = 3'd3,
    ST_INVALID = 3'd4,
    ST_BADSLOT = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RMW,
    S_READ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] file_size;
    logic [7:0]  attributes;
    logic [31:0] parent_id;
    logic [31:0] entry_block;
    logic [15:0] entry_position;
    logic [15:0] write_time;
    logic [15:0] write_date;
  } meta_t;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [31:0]          key;
    logic [SLOT_BITS-1:0] slot;
    meta_t                meta;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]   slot_out;
    logic [REF_BITS-1:0]    ref_count;
    meta_t                  meta;
    logic [CNT_BITS-1:0]    hit_total;
    logic [CNT_BITS-1:0]    miss_total;
  } resp_t;

endpackage

>>> design/rlec_if.sv
// Valid/ready channel interfaces for requests and results.
interface rlec_req_if;
  import rlec_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rlec_resp_if;
  import rlec_pkg::*;
  logic  valid;
  logic  ready;
  resp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/refcounted_lru_entry_cache.sv
// Top level: refcounted LRU entry cache with a sequential scan over the table.
//
// One request channel (req) and one result channel (resp), valid/ready.
// Every request item gives exactly one result item.
// Lookup, get and remove with a valid key scan all ENTRIES slots, one slot
// per cycle, through a single compare unit. The unit matches the key, finds
// the lowest free slot and tracks the oldest zero-reference entry.
// Steps: a key hit, create or remove hit runs scan, decide, count update,
// read back and emit; a key miss or a full table runs scan, decide and
// emit; add/drop reference on a valid slot runs decide, count update, read
// back and emit; a bad slot, bad key or bad op runs decide and emit.
// A new request is taken only once the last one has left its emit step;
// req.ready is high only in idle. The slot scan bounds the rate. Metadata,
// key, count and age live in memories with one registered read port each.
// Reset (rst, synchronous) clears all valid bits, the age clock and the
// hit and miss counters; the other stores hold garbage until written.
// A stalled receiver holds the result register. The next item is still
// accepted and processed, then waits in its emit step until the register
// is free.
module refcounted_lru_entry_cache #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 32
) (
  input logic clk,
  input logic rst,
  rlec_req_if.sink    req,
  rlec_resp_if.source resp
);
  import rlec_pkg::*;

  localparam int IB = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CB = IB + 1;

  // storage
  logic [ENTRIES-1:0] valid;
  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [REF_BITS-1:0] ref_mem [ENTRIES];
  logic [AGE_BITS-1:0] age_mem [ENTRIES];
  meta_t               meta_mem [ENTRIES];

  state_t state, state_next;
  req_t   rq;
  logic [KEY_BITS-1:0] rkey;
  logic [CB-1:0] scan;      // read address issued
  logic [IB-1:0] cur;       // index whose read data is present
  logic          cur_ok;
  logic          found, free_ok, ev_ok;
  logic [IB-1:0] found_i, free_i, ev_i, sel;
  logic [AGE_BITS-1:0] ev_el;
  logic [AGE_BITS-1:0] age_clock;
  logic [CNT_BITS-1:0] hits, misses;
  logic [KEY_BITS-1:0] key_rd;
  logic [REF_BITS-1:0] ref_rd;
  logic [AGE_BITS-1:0] age_rd;
  meta_t               meta_rd;
  logic [STATUS_BITS-1:0] st;
  logic                emit_entry;
  logic [IB-1:0]       rd_addr;
  logic                out_valid;
  resp_t               out_data;
  resp_t               out_next;
  // status latched at decide; hit-on-get remembered for the count update
  logic [STATUS_BITS-1:0] rq_status;
  logic                   ref_was_hit;

  wire logic is_key_op = (rq.op == OP_LOOKUP) || (rq.op == OP_GET) || (rq.op == OP_REMOVE);
  wire logic is_slot_op = (rq.op == OP_ADDREF) || (rq.op == OP_DROP);
  wire logic slot_in = ({{(32-SLOT_BITS){1'b0}}, rq.slot} < 32'(ENTRIES));
  wire logic [IB-1:0] slot_i = IB'(rq.slot);
  wire logic [AGE_BITS-1:0] el = age_clock - age_rd;
  // a valid-key lookup, get or remove goes straight to the scan
  wire logic start_scan = ((req.data.op == OP_LOOKUP) || (req.data.op == OP_GET) ||
                           (req.data.op == OP_REMOVE)) &&
                          (KEY_BITS'(req.data.key) >= KEY_BITS'(2));
  // result register free, or freed at this edge
  wire logic emit_go = !out_valid || resp.ready;

  assign req.ready  = (state == S_IDLE);
  assign resp.valid = out_valid;
  assign resp.data  = out_data;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req.valid && req.ready) state_next = start_scan ? S_SCAN : S_DECIDE;
      S_SCAN: if (!cur_ok && scan == CB'(ENTRIES)) state_next = S_DECIDE;
      S_DECIDE: state_next = ((st == ST_HIT) || (st == ST_CREATED)) ? S_RMW : S_EMIT;
      S_RMW:  state_next = S_READ;
      S_READ: state_next = S_EMIT;
      S_EMIT: if (emit_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // decide outcome after the scan, or from the slot for slot ops
  always_comb begin
    st  = ST_INVALID;
    sel = found_i;
    if (is_slot_op) begin
      st  = (slot_in && valid[slot_i]) ? ST_HIT : ST_BADSLOT;
      sel = slot_i;
    end else if (is_key_op && rkey >= KEY_BITS'(2)) begin
      if (found) st = ST_HIT;
      else if (rq.op == OP_GET) begin
        if (free_ok) begin st = ST_CREATED; sel = free_i; end
        else if (ev_ok) begin st = ST_CREATED; sel = ev_i; end
        else st = ST_FULL;
      end else st = ST_MISS;
    end
  end

  always_comb begin
    rd_addr = scan[IB-1:0];
    if (state == S_DECIDE) rd_addr = sel;
    else if (state == S_RMW || state == S_READ || state == S_EMIT) rd_addr = found_i;
  end

  // result item
  always_comb begin
    out_next            = '0;
    out_next.status     = rq_status;
    out_next.hit_total  = hits;
    out_next.miss_total = misses;
    if (emit_entry) begin
      out_next.slot_out  = SLOT_BITS'(found_i);
      out_next.ref_count = ref_rd;
      out_next.meta      = meta_rd;
    end
  end

  // memory reads, registered
  always_ff @(posedge clk) begin
    key_rd  <= key_mem[rd_addr];
    ref_rd  <= ref_mem[rd_addr];
    age_rd  <= age_mem[rd_addr];
    meta_rd <= meta_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      age_clock <= '0;
      hits      <= '0;
      misses    <= '0;
      out_valid <= 1'b0;
      scan      <= '0;
      cur_ok    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && emit_go) begin
        out_valid <= 1'b1;
        out_data  <= out_next;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (req.valid && req.ready) begin
          rq     <= req.data;
          rkey   <= KEY_BITS'(req.data.key);
          scan   <= '0;
          cur_ok <= 1'b0;
          found <= 1'b0; free_ok <= 1'b0; ev_ok <= 1'b0;
          found_i <= '0; free_i <= '0; ev_i <= '0; ev_el <= '0;
        end
        S_SCAN: begin
          // one compare step per slot on the registered read data
          if (cur_ok) begin
            if (valid[cur] && key_rd == rkey && !found) begin
              found <= 1'b1; found_i <= cur;
            end
            if (!valid[cur] && !free_ok) begin
              free_ok <= 1'b1; free_i <= cur;
            end
            if (valid[cur] && ref_rd == '0 && (!ev_ok || el > ev_el)) begin
              ev_ok <= 1'b1; ev_i <= cur; ev_el <= el;
            end
          end
          cur_ok <= (scan < CB'(ENTRIES));
          cur    <= scan[IB-1:0];
          if (scan < CB'(ENTRIES)) scan <= scan + CB'(1);
        end
        S_DECIDE: begin
          emit_entry <= (st == ST_HIT) || (st == ST_CREATED);
          found_i    <= sel;
          if (st == ST_HIT && rq.op == OP_LOOKUP) hits <= hits + 1'b1;
          if (st == ST_MISS && rq.op == OP_LOOKUP) misses <= misses + 1'b1;
          if (st == ST_HIT && rq.op == OP_GET) hits <= hits + 1'b1;
          if (st == ST_CREATED) misses <= misses + 1'b1;
          if (st == ST_HIT && rq.op == OP_GET) meta_mem[sel] <= rq.meta;
          if (st == ST_CREATED) begin
            valid[sel]    <= 1'b1;
            key_mem[sel]  <= rkey;
            ref_mem[sel]  <= REF_BITS'(1);
            age_mem[sel]  <= '0;
            meta_mem[sel] <= rq.meta;
          end
          if (st == ST_HIT && rq.op == OP_REMOVE) valid[sel] <= 1'b0;
        end
        S_RMW: begin
          // ref_rd now holds the selected entry's count from before the decide step's writes
          if ((rq.op == OP_ADDREF || (rq.op == OP_GET && ref_was_hit)) && ref_rd != REF_MAX)
            ref_mem[found_i] <= ref_rd + 1'b1;
          if (rq.op == OP_DROP && ref_rd != '0) begin
            ref_mem[found_i] <= ref_rd - 1'b1;
            if (ref_rd == REF_BITS'(1)) begin
              age_mem[found_i] <= age_clock;
              age_clock        <= age_clock + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      rq_status   <= st;
      ref_was_hit <= (st == ST_HIT);
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> out_valid) else $error("result not raised");
  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && !resp.ready) |=> (state == S_EMIT))
    else $error("result register overwritten");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !resp.ready) |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
endmodule
